// ----- hw/rtl/flt_pkg.sv -----
// ----------------------------------------------------------------------------
// Fault log table package
// Shared sizes, field widths, codes and the control/status bundles that
// join the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package flt_pkg;

    // Table depth and derived widths.
    localparam int MAX_FAULTS = 16;
    localparam int IDX_W      = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1;
    localparam int CNT_W      = $clog2(MAX_FAULTS + 1);

    // Field widths of the ports.
    localparam int KIND_W      = 3;
    localparam int COMP_W      = 8;
    localparam int CODE_W      = 8;
    localparam int ID_W        = 16;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int ENTRY_W     = COMP_W + CODE_W + ID_W;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_OVF_COMPONENT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OVF_CODE      = 2'd1;

    // Operation codes carried on the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_RAISE          = 3'd0,
        KIND_CLEAR_EXACT    = 3'd1,
        KIND_CLEAR_MATCH    = 3'd2,
        KIND_DISMISS_OLDEST = 3'd3,
        KIND_DISMISS_ALL    = 3'd4,
        KIND_QUERY          = 3'd5
    } t_kind;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic [COMP_W-1:0] comp;
        logic [CODE_W-1:0] code;
        logic [ID_W-1:0]   id;
    } t_entry;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_HEAD,
        ST_LOAD
    } t_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic decide;
        logic shift;
        logic head;
        logic load;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/flt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module flt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic                                        i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fault log table sequencer
// Steps one item through scan, decide, shift, head read and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module flt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire flt_pkg::t_status i_status,
    output flt_pkg::t_cmd         o_cmd
);

    flt_pkg::t_state r_state;
    flt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            flt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = flt_pkg::ST_SCAN;
                end
            end
            flt_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.walk_done) begin
                    n_state = flt_pkg::ST_DECIDE;
                end
            end
            flt_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = flt_pkg::ST_SHIFT;
            end
            flt_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.walk_done) begin
                    n_state = flt_pkg::ST_HEAD;
                end
            end
            flt_pkg::ST_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = flt_pkg::ST_LOAD;
            end
            flt_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = flt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = flt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flt_dp.sv -----
// ----------------------------------------------------------------------------
// Fault log table datapath
// Entry RAM, walk pointer, match flags, count, id counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flt_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire flt_pkg::t_cmd                    i_cmd,
    output flt_pkg::t_status                      o_status,
    input  wire logic                             i_cfg_write,
    input  wire logic [flt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [flt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [flt_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [flt_pkg::COMP_W-1:0]       i_component,
    input  wire logic [flt_pkg::CODE_W-1:0]       i_fault_code,
    input  wire logic [flt_pkg::ID_W-1:0]         i_fault_id,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_changed,
    output logic [flt_pkg::ID_W-1:0]              o_assigned_id,
    output logic [flt_pkg::COUNT_W-1:0]           o_entry_count,
    output logic                                  o_oldest_valid,
    output logic [flt_pkg::COMP_W-1:0]            o_oldest_component,
    output logic [flt_pkg::CODE_W-1:0]            o_oldest_code,
    output logic [flt_pkg::ID_W-1:0]              o_oldest_id,
    output logic                                  o_present
);

    localparam int CW = flt_pkg::CNT_W;
    localparam int IW = flt_pkg::IDX_W;
    localparam int OW = flt_pkg::COUNT_W;
    localparam int MF = flt_pkg::MAX_FAULTS;

    // Configuration registers.
    logic [flt_pkg::COMP_W-1:0] r_ovf_comp;
    logic [flt_pkg::CODE_W-1:0] r_ovf_code;

    // Latched item.
    logic [flt_pkg::KIND_W-1:0] r_kind;
    logic [flt_pkg::COMP_W-1:0] r_comp;
    logic [flt_pkg::CODE_W-1:0] r_code;
    logic [flt_pkg::ID_W-1:0]   r_fid;

    // Table state.
    logic [CW-1:0]              r_count;
    logic [flt_pkg::ID_W-1:0]   r_next_id;

    // Walk over the table.
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_limit;
    logic [CW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic          issue;

    // Scan results.
    logic          r_first_hit;
    logic [IW-1:0] r_first_pos;
    logic          r_exact_hit;
    logic [IW-1:0] r_exact_pos;
    logic [1:0]    r_hits;
    logic          r_head_hit;

    // Item results waiting for the head read.
    logic                     r_changed;
    logic [flt_pkg::ID_W-1:0] r_assigned;
    logic                     r_present;

    // RAM ports.
    logic             ram_wr_en;
    logic [IW-1:0]    ram_wr_addr;
    flt_pkg::t_entry  ram_wr_data;
    logic             ram_rd_en;
    logic [IW-1:0]    ram_rd_addr;
    flt_pkg::t_entry  ram_rd_data;

    // Decision terms.
    logic             ovf_name;
    logic             has_one;
    logic             has_two;
    logic             d_changed;
    logic [flt_pkg::ID_W-1:0] d_assigned;
    logic             d_present;
    logic             d_append;
    flt_pkg::t_entry  d_entry;
    logic             d_remove;
    logic [IW-1:0]    d_rm_pos;
    logic             d_clear_all;
    logic             d_bump_id;
    logic             pair_hit;

    assign issue    = (i_cmd.scan || i_cmd.shift) && (r_ptr < r_limit);
    assign pair_hit = (ram_rd_data.comp == r_comp) && (ram_rd_data.code == r_code);

    assign o_status.walk_done = (r_ptr >= r_limit) && !r_rd_vld;
    assign o_status.out_free  = !o_out_valid || i_out_ready;

    assign ram_rd_en   = issue || i_cmd.head;
    assign ram_rd_addr = i_cmd.head ? '0 : r_ptr[IW-1:0];

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_count[IW-1:0];
        ram_wr_data = d_entry;
        if (i_cmd.decide && d_append) begin
            ram_wr_en = 1'b1;
        end else if (i_cmd.shift && r_rd_vld) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IW'(r_rd_idx - CW'(1));
            ram_wr_data = ram_rd_data;
        end
    end

    always_comb begin
        ovf_name    = (r_comp == r_ovf_comp) && (r_code == r_ovf_code);
        has_one     = (r_hits != 2'd0);
        has_two     = (r_hits == 2'd2);
        d_changed   = 1'b0;
        d_assigned  = '0;
        d_present   = has_one;
        d_append    = 1'b0;
        d_entry     = '{comp: r_comp, code: r_code, id: r_next_id};
        d_remove    = 1'b0;
        d_rm_pos    = '0;
        d_clear_all = 1'b0;
        d_bump_id   = 1'b0;
        unique case (r_kind)
            flt_pkg::KIND_RAISE: begin
                if (!ovf_name && !r_first_hit) begin
                    d_assigned = r_next_id;
                    d_bump_id  = 1'b1;
                    if (r_count < CW'(MF - 1)) begin
                        d_append  = 1'b1;
                        d_changed = 1'b1;
                        d_present = 1'b1;
                    end else if (r_count < CW'(MF)) begin
                        // Last free slot takes the overflow marker.
                        d_append  = 1'b1;
                        d_changed = 1'b1;
                        d_entry   = '{comp: r_ovf_comp, code: r_ovf_code, id: r_next_id};
                    end
                end
            end
            flt_pkg::KIND_CLEAR_EXACT: begin
                if (r_exact_hit) begin
                    d_remove  = 1'b1;
                    d_rm_pos  = r_exact_pos;
                    d_changed = 1'b1;
                    d_present = has_two;
                end
            end
            flt_pkg::KIND_CLEAR_MATCH: begin
                if (r_first_hit) begin
                    d_remove  = 1'b1;
                    d_rm_pos  = r_first_pos;
                    d_changed = 1'b1;
                    d_present = has_two;
                end
            end
            flt_pkg::KIND_DISMISS_OLDEST: begin
                if (r_count != '0) begin
                    d_remove  = 1'b1;
                    d_changed = 1'b1;
                    d_present = has_two || (has_one && !r_head_hit);
                end
            end
            flt_pkg::KIND_DISMISS_ALL: begin
                if (r_count != '0) begin
                    d_clear_all = 1'b1;
                    d_changed   = 1'b1;
                end
                d_present = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_comp  <= '0;
            r_ovf_code  <= '0;
            r_count     <= '0;
            r_next_id   <= flt_pkg::ID_W'(1);
            r_rd_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                if (i_cfg_index == flt_pkg::REG_OVF_COMPONENT) begin
                    r_ovf_comp <= i_cfg_data;
                end else if (i_cfg_index == flt_pkg::REG_OVF_CODE) begin
                    r_ovf_code <= i_cfg_data;
                end
            end
            r_rd_vld <= issue;
            if (i_cmd.decide) begin
                if (d_append) begin
                    r_count <= r_count + CW'(1);
                end else if (d_remove) begin
                    r_count <= r_count - CW'(1);
                end else if (d_clear_all) begin
                    r_count <= '0;
                end
                if (d_bump_id) begin
                    r_next_id <= r_next_id + flt_pkg::ID_W'(1);
                end
            end
            if (i_cmd.load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Walk pointer, scan flags and payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind      <= i_kind;
            r_comp      <= i_component;
            r_code      <= i_fault_code;
            r_fid       <= i_fault_id;
            r_ptr       <= '0;
            r_limit     <= r_count;
            r_first_hit <= 1'b0;
            r_exact_hit <= 1'b0;
            r_hits      <= 2'd0;
            r_head_hit  <= 1'b0;
        end
        if (issue) begin
            r_ptr <= r_ptr + CW'(1);
        end
        r_rd_idx <= r_ptr;
        if (i_cmd.scan && r_rd_vld && pair_hit) begin
            if (!r_first_hit) begin
                r_first_hit <= 1'b1;
                r_first_pos <= r_rd_idx[IW-1:0];
            end
            if (!has_two) begin
                r_hits <= r_hits + 2'd1;
            end
            if (r_rd_idx == '0) begin
                r_head_hit <= 1'b1;
            end
            if ((ram_rd_data.id == r_fid) && !r_exact_hit) begin
                r_exact_hit <= 1'b1;
                r_exact_pos <= r_rd_idx[IW-1:0];
            end
        end
        if (i_cmd.decide) begin
            r_changed  <= d_changed;
            r_assigned <= d_assigned;
            r_present  <= d_present;
            // The shift walk starts just past the removed entry, or is empty.
            if (d_remove) begin
                r_ptr <= CW'(d_rm_pos) + CW'(1);
            end else begin
                r_ptr <= r_limit;
            end
        end
        if (i_cmd.load) begin
            o_changed      <= r_changed;
            o_assigned_id  <= r_assigned;
            o_entry_count  <= OW'(r_count);
            o_present      <= r_present;
            o_oldest_valid <= (r_count != '0);
            if (r_count != '0) begin
                o_oldest_component <= ram_rd_data.comp;
                o_oldest_code      <= ram_rd_data.code;
                o_oldest_id        <= ram_rd_data.id;
            end else begin
                o_oldest_component <= '0;
                o_oldest_code      <= '0;
                o_oldest_id        <= '0;
            end
        end
    end

    flt_ram #(
        .WIDTH (flt_pkg::ENTRY_W),
        .DEPTH (flt_pkg::MAX_FAULTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/fault_log_table.sv -----
// ----------------------------------------------------------------------------
// Fault log table
// Ordered table of active faults with raise, clear, dismiss and query.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (i_in_valid / o_in_ready) with a kind,
// a component, a fault code and an id. Each accepted command produces exactly
// one result transfer on the output channel (o_out_valid / i_out_ready) that
// describes the table after the command: change flag, id taken by a raise,
// entry count, the oldest entry and whether the command's component and code
// are held.
// The overflow marker component and code are written over the configuration
// channel (i_cfg_valid / o_cfg_ready, always ready). The user must write them
// only while no command is open; the block itself does not enforce this.
// Timing: one command at a time. A command goes through a scan that reads
// every entry through the single RAM read port, a decide step, a second pass
// that moves the entries behind a removed one forward, a read of the oldest
// entry and the load of the result. The next command is taken in the cycle
// after the load at the earliest.
// Reset (synchronous, active low) empties the table, sets the next id to one
// and clears the overflow marker registers; the entry RAM itself is not
// cleared. A stalled receiver holds the result in the output register; the
// next command is still taken and worked on, and waits only for its load.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_log_table (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [flt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [flt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Command channel.
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [flt_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [flt_pkg::COMP_W-1:0]       i_component,
    input  wire logic [flt_pkg::CODE_W-1:0]       i_fault_code,
    input  wire logic [flt_pkg::ID_W-1:0]         i_fault_id,
    // Result channel.
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_changed,
    output logic [flt_pkg::ID_W-1:0]              o_assigned_id,
    output logic [flt_pkg::COUNT_W-1:0]           o_entry_count,
    output logic                                  o_oldest_valid,
    output logic [flt_pkg::COMP_W-1:0]            o_oldest_component,
    output logic [flt_pkg::CODE_W-1:0]            o_oldest_code,
    output logic [flt_pkg::ID_W-1:0]              o_oldest_id,
    output logic                                  o_present
);

    flt_pkg::t_cmd    cmd;
    flt_pkg::t_status status;

    // Configuration writes land in plain registers and never stall.
    assign o_cfg_ready = 1'b1;

    // The sequencer owns the handshake on the command side and walks each
    // command through its phases.
    flt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the table, the match logic and the result register.
    flt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_write        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_kind             (i_kind),
        .i_component        (i_component),
        .i_fault_code       (i_fault_code),
        .i_fault_id         (i_fault_id),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_changed          (o_changed),
        .o_assigned_id      (o_assigned_id),
        .o_entry_count      (o_entry_count),
        .o_oldest_valid     (o_oldest_valid),
        .o_oldest_component (o_oldest_component),
        .o_oldest_code      (o_oldest_code),
        .o_oldest_id        (o_oldest_id),
        .o_present          (o_present)
    );

    // A result flags an oldest entry exactly when the table is not empty.
    a_oldest_matches_count : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_oldest_valid == (o_entry_count != '0))
    ) else $error("oldest_valid disagrees with entry_count");

    // An empty table reports an all-zero oldest entry.
    a_empty_oldest_zero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_oldest_valid) |->
            (o_oldest_component == '0 && o_oldest_code == '0 && o_oldest_id == '0)
    ) else $error("empty table reports a non-zero oldest entry");

    // Only one command is open at a time.
    a_one_open_command : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("command channel ready right after a transfer");

endmodule

`default_nettype wire
